// ===== rtl/core/tts_pkg.sv =====
// Package for the timer task scheduler: result kinds, register indices and shared types.
// No dependencies.
`default_nettype none
package tts_pkg;
    localparam logic [1:0] KIND_ADD_OK   = 2'd0;
    localparam logic [1:0] KIND_ADD_FULL = 2'd1;
    localparam logic [1:0] KIND_FIRED    = 2'd2;
    localparam logic [1:0] KIND_WAIT     = 2'd3;

    localparam logic [1:0] CFG_WAIT_FLOOR   = 2'd0;
    localparam logic [1:0] CFG_WAIT_CEILING = 2'd1;
    localparam logic [1:0] CFG_LATE_LIMIT   = 2'd2;

    // candidate handed along the scan chain
    typedef struct packed {
        logic        found;
        logic [31:0] rel;
        logic [7:0]  slot;
    } cand_t;

    // control from sequencer to every cell
    typedef struct packed {
        logic        clr;
        logic        write;
        logic        retire;
        logic        resched;
        logic [7:0]  slot;
        logic [7:0]  task_id;
        logic [31:0] due;
        logic [23:0] interval;
        logic        periodic;
    } cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/tts_cell.sv =====
// One timer slot; compares its signed distance to now against the candidate
// arriving from the previous cell and registers the better one. Uses tts_pkg.
`default_nettype none
module tts_cell #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  tts_pkg::cell_ctl_t  ctl,
    input  wire  [31:0]         now,
    input  wire  [31:0]         new_due,
    input  tts_pkg::cand_t      cand_in,
    output tts_pkg::cand_t      cand_out,
    output logic                valid,
    output logic [7:0]          task_id,
    output logic [31:0]         due,
    output logic [23:0]         interval,
    output logic                periodic
);
    import tts_pkg::*;

    logic        valid_reg;
    logic [31:0] due_reg;
    logic [23:0] ivl_reg;
    logic        per_reg;
    logic [7:0]  id_reg;
    cand_t       cand_reg;
    logic [31:0] rel;
    logic        better;
    logic        hit;

    assign hit = (ctl.slot[IDX_W-1:0] == IDX_W'(IDX));
    assign rel = due_reg - now;
    // strictly smaller wins, so the lower slot keeps ties
    assign better = valid_reg &&
                    (!cand_in.found || ($signed(rel) < $signed(cand_in.rel)));

    // slot state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.write && hit) begin
            valid_reg <= 1'b1;
        end else if (ctl.retire && hit) begin
            valid_reg <= 1'b0;
        end
        if (ctl.write && hit) begin
            due_reg <= ctl.due;
            ivl_reg <= ctl.interval;
            per_reg <= ctl.periodic;
            id_reg  <= ctl.task_id;
        end else if (ctl.resched && hit) begin
            due_reg <= new_due;
        end
    end

    // scan stage
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr) begin
            cand_reg <= '0;
        end else if (better) begin
            cand_reg <= '{found: 1'b1, rel: rel, slot: 8'(IDX)};
        end else begin
            cand_reg <= cand_in;
        end
    end

    assign cand_out = cand_reg;
    assign valid    = valid_reg;
    assign task_id  = id_reg;
    assign due      = due_reg;
    assign interval = ivl_reg;
    assign periodic = per_reg;
endmodule
`default_nettype wire

// ===== rtl/core/timer_task_scheduler.sv =====
// Top level of the timer task scheduler: sequencer, output register and a
// chain of tts_cell slots. Uses tts_pkg and tts_cell.
//
//  channel | direction | contents
//  s_      | in        | tdata = task_id, due_time, interval, periodic, now; tuser = mode
//  m_      | out       | tdata = fired_id, fire_time, wait_ms; tuser = kind; tlast = last
//  cfg_    | in        | register index and 16-bit write data
//
// An add finds the lowest free slot with a counter walking the valid bits.
// Each head search in a poll clears the chain and ripples the candidate down the
// NUM_SLOTS cells; each firing is followed by a new search, and the poll ends
// with the wait report. Synchronous active-low reset clears all slots' valid
// flags, the output valid and the counters, and sets the three config registers to their defaults.
// A stalled m_ side holds the sequencer; s_tready is high only between items.
`default_nettype none
module timer_task_scheduler #(
    parameter int NUM_SLOTS = 16,
    parameter int MAX_FIRES = 63
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [103:0] s_tdata,  // task_id[7:0] due_time[39:8] interval[63:40]
                                   // periodic[64] now[96:65], zero pad
    input  wire         s_tuser,   // mode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,   // fired_id[7:0] fire_time[39:8] wait_ms[70:40], pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    import tts_pkg::*;

    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 2);
    localparam int FIRE_W = $clog2(MAX_FIRES + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADD  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_HEAD = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [15:0] floor_reg, ceil_reg, late_reg;
    logic [7:0]  id_in_reg;
    logic [31:0] due_in_reg, now_reg;
    logic [23:0] ivl_in_reg;
    logic        per_in_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [FIRE_W-1:0] fires_reg;
    logic        fired_any_reg;

    logic        o_valid_reg;
    logic [1:0]  o_kind_reg;
    logic [7:0]  o_id_reg;
    logic [31:0] o_time_reg;
    logic [30:0] o_wait_reg;
    logic        o_last_reg;

    cell_ctl_t ctl;
    cand_t     chain [NUM_SLOTS+1];
    logic [NUM_SLOTS-1:0] v_vec;
    logic [7:0]  ids  [NUM_SLOTS];
    logic [31:0] dues [NUM_SLOTS];
    logic [23:0] ivls [NUM_SLOTS];
    logic        pers [NUM_SLOTS];
    logic [31:0] new_due;
    logic [7:0]  free_slot;
    logic        free_found;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
            tts_cell #(.IDX_W(IDX_W), .IDX(g)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .now(now_reg),
                .new_due(new_due), .cand_in(chain[g]), .cand_out(chain[g+1]),
                .valid(v_vec[g]), .task_id(ids[g]), .due(dues[g]),
                .interval(ivls[g]), .periodic(pers[g])
            );
        end
    endgenerate

    // lowest free slot, found by a counter walking the valid bits
    logic [7:0]  free_reg;
    logic        free_hit_reg;
    assign free_slot  = free_reg;
    assign free_found = free_hit_reg;

    // head data
    cand_t       head;
    logic [IDX_W-1:0] hidx;
    logic        late;
    logic [31:0] ft;
    assign head = chain[NUM_SLOTS];
    assign hidx = head.slot[IDX_W-1:0];
    assign late = $signed(head.rel) < -$signed({16'd0, late_reg});
    assign ft   = late ? now_reg : dues[hidx];
    assign new_due = {8'd0, ivls[hidx]} + ft;

    logic out_free;
    logic o_load;
    assign out_free = !o_valid_reg || m_tready;
    // output register takes a new result this cycle
    assign o_load   = out_free && ((state_reg == ST_ADD && cnt_reg == CNT_W'(NUM_SLOTS))
                                   || state_reg == ST_HEAD);

    always_comb begin
        state_next = state_reg;
        ctl = '0;
        ctl.slot     = head.slot;
        ctl.task_id  = id_in_reg;
        ctl.due      = due_in_reg;
        ctl.interval = ivl_in_reg;
        ctl.periodic = per_in_reg;
        case (state_reg)
            ST_IDLE: begin
                ctl.clr = 1'b1;
                if (s_tvalid) begin
                    state_next = s_tuser ? ST_SCAN : ST_ADD;
                end
            end
            ST_ADD: begin
                if (cnt_reg == CNT_W'(NUM_SLOTS) && out_free) begin
                    ctl.write = free_found;
                    ctl.slot  = free_slot;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == CNT_W'(NUM_SLOTS)) begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (out_free) begin
                    ctl.clr = 1'b1;
                    if (!head.found || !head.rel[31] && head.rel != 32'd0
                        || fires_reg == FIRE_W'(MAX_FIRES)) begin
                        state_next = ST_OUT;
                    end else begin
                        ctl.resched = pers[hidx];
                        ctl.retire  = !pers[hidx];
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            floor_reg   <= 16'd50;
            ceil_reg    <= 16'd1000;
            late_reg    <= 16'd1000;
            o_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            fires_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (o_valid_reg && m_tready && !o_load) begin
                o_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WAIT_FLOOR:   floor_reg <= cfg_data;
                    CFG_WAIT_CEILING: ceil_reg  <= cfg_data;
                    CFG_LATE_LIMIT:   late_reg  <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    cnt_reg       <= '0;
                    fires_reg     <= '0;
                    fired_any_reg <= 1'b0;
                    free_hit_reg  <= 1'b0;
                    free_reg      <= '0;
                    if (s_tvalid) begin
                        id_in_reg  <= s_tdata[7:0];
                        due_in_reg <= s_tdata[39:8];
                        ivl_in_reg <= s_tdata[63:40];
                        per_in_reg <= s_tdata[64];
                        now_reg    <= s_tdata[96:65];
                    end
                end
                ST_ADD: begin
                    if (cnt_reg != CNT_W'(NUM_SLOTS)) begin
                        if (!free_hit_reg && !v_vec[cnt_reg[IDX_W-1:0]]) begin
                            free_hit_reg <= 1'b1;
                            free_reg     <= 8'(cnt_reg);
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end else if (out_free) begin
                        o_valid_reg <= 1'b1;
                        o_kind_reg  <= free_found ? KIND_ADD_OK : KIND_ADD_FULL;
                        o_id_reg    <= id_in_reg;
                        o_time_reg  <= '0;
                        o_wait_reg  <= '0;
                        o_last_reg  <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_HEAD: begin
                    cnt_reg <= '0;
                    if (out_free) begin
                        o_valid_reg <= 1'b1;
                        if (!head.found) begin
                            o_kind_reg <= KIND_WAIT;
                            o_id_reg   <= '0;
                            o_time_reg <= '0;
                            o_wait_reg <= fired_any_reg ? {15'd0, floor_reg}
                                                        : {15'd0, ceil_reg};
                            o_last_reg <= 1'b1;
                        end else if (!head.rel[31] && head.rel != 32'd0) begin
                            o_kind_reg <= KIND_WAIT;
                            o_id_reg   <= '0;
                            o_time_reg <= '0;
                            o_wait_reg <= head.rel[30:0];
                            o_last_reg <= 1'b1;
                        end else if (fires_reg == FIRE_W'(MAX_FIRES)) begin
                            o_kind_reg <= KIND_WAIT;
                            o_id_reg   <= '0;
                            o_time_reg <= '0;
                            o_wait_reg <= '0;
                            o_last_reg <= 1'b1;
                        end else begin
                            o_kind_reg    <= KIND_FIRED;
                            o_id_reg      <= ids[hidx];
                            o_time_reg    <= ft;
                            o_wait_reg    <= '0;
                            o_last_reg    <= 1'b0;
                            fires_reg     <= fires_reg + 1'b1;
                            fired_any_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = o_valid_reg;
    assign m_tdata   = {1'b0, o_wait_reg, o_time_reg, o_id_reg};
    assign m_tuser   = o_kind_reg;
    assign m_tlast   = o_last_reg;

`ifndef SYNTH
    // fire count never exceeds the cap
    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fires_reg <= FIRE_W'(MAX_FIRES)) else $error("fire cap exceeded");
    // a wait report is always the last result of its item
    a_wait_last: assert property (@(posedge aclk) disable iff (!aresetn)
        o_valid_reg && o_kind_reg == KIND_WAIT |-> o_last_reg)
        else $error("wait report not last");
    // an accepted input always starts an item
    a_idle_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("item not started");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/tts_checker.sv =====
// Checker for the timer task scheduler: predicts the results of every accepted
// input transaction and compares them with the result channel. Uses tts_pkg.
`timescale 1ns / 100ps
module tts_checker #(
    parameter int NUM_SLOTS = 16,
    parameter int MAX_FIRES = 63
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire  [103:0] s_tdata,
    input  wire          s_tuser,
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire  [71:0]  m_tdata,
    input  wire  [1:0]   m_tuser,
    input  wire          m_tlast,
    input  wire          cfg_valid,
    input  wire          cfg_ready,
    input  wire  [1:0]   cfg_index,
    input  wire  [15:0]  cfg_data,
    output int           errors,
    output int           pending
);
    import tts_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  fired_id;
        logic [31:0] fire_time;
        logic [30:0] wait_ms;
        logic        last;
    } sched_result_t;

    sched_result_t sched_results_q[$];

    // predictor copy of registers and slots
    logic [15:0] floor_r, ceiling_r, late_r;
    logic        tab_valid[NUM_SLOTS];
    logic [31:0] tab_due[NUM_SLOTS];
    logic [23:0] tab_ivl[NUM_SLOTS];
    logic        tab_per[NUM_SLOTS];
    logic [7:0]  tab_id[NUM_SLOTS];

    assign pending = sched_results_q.size();

    function automatic longint signed_gap(logic [31:0] due, logic [31:0] now);
        logic [31:0] u;
        u = due - now;
        return longint'($signed(u));
    endfunction

    task automatic push_result(logic [1:0] kind, logic [7:0] id, logic [31:0] ft,
                               logic [30:0] wt, logic last);
        sched_result_t r;
        r.kind = kind; r.fired_id = id; r.fire_time = ft; r.wait_ms = wt; r.last = last;
        sched_results_q.push_back(r);
    endtask

    // work out the results of one input transaction
    task automatic schedule_step(logic mode, logic [7:0] id, logic [31:0] due,
                                 logic [23:0] ivl, logic per, logic [31:0] now);
        int          head;
        int          fires;
        longint      d, hd;
        logic [31:0] ft;
        logic [30:0] wt;
        bit          done;
        if (mode == 1'b0) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!tab_valid[i]) begin
                    tab_valid[i] = 1'b1;
                    tab_due[i] = due;
                    tab_ivl[i] = ivl;
                    tab_per[i] = per;
                    tab_id[i] = id;
                    push_result(KIND_ADD_OK, id, '0, '0, 1'b1);
                    return;
                end
            end
            push_result(KIND_ADD_FULL, id, '0, '0, 1'b1);
            return;
        end
        wt = 31'(ceiling_r);
        fires = 0;
        done = 0;
        while (!done) begin
            head = -1;
            hd = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (tab_valid[i]) begin
                    d = signed_gap(tab_due[i], now);
                    if (head < 0 || d < hd) begin
                        head = i;
                        hd = d;
                    end
                end
            end
            if (head < 0) begin
                done = 1;
            end else if (hd > 0) begin
                wt = 31'(hd);
                done = 1;
            end else if (fires >= MAX_FIRES) begin
                wt = '0;
                done = 1;
            end else begin
                ft = (hd < -longint'(late_r)) ? now : tab_due[head];
                push_result(KIND_FIRED, tab_id[head], ft, '0, 1'b0);
                fires++;
                if (tab_per[head])
                    tab_due[head] = ft + 32'(tab_ivl[head]);
                else
                    tab_valid[head] = 1'b0;
                wt = 31'(floor_r);
            end
        end
        push_result(KIND_WAIT, '0, '0, wt, 1'b1);
    endtask

    always @(posedge aclk) begin
        sched_result_t e;
        if (!aresetn) begin
            floor_r = 16'd50;
            ceiling_r = 16'd1000;
            late_r = 16'd1000;
            for (int i = 0; i < NUM_SLOTS; i++) tab_valid[i] = 1'b0;
            sched_results_q.delete();
            errors = 0;
        end else begin
            // result transaction against the oldest expectation
            if (m_tvalid && m_tready) begin
                if (sched_results_q.size() == 0) begin
                    $error("unexpected result: kind %0d id %0h", m_tuser, m_tdata[7:0]);
                    errors++;
                end else begin
                    e = sched_results_q.pop_front();
                    if (m_tuser !== e.kind) begin
                        $error("kind: expected %0d actual %0d", e.kind, m_tuser);
                        errors++;
                    end
                    if (m_tdata[7:0] !== e.fired_id) begin
                        $error("fired_id: expected %0h actual %0h", e.fired_id, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[39:8] !== e.fire_time) begin
                        $error("fire_time: expected %0h actual %0h", e.fire_time,
                               m_tdata[39:8]);
                        errors++;
                    end
                    if (m_tdata[70:40] !== e.wait_ms) begin
                        $error("wait_ms: expected %0d actual %0d", e.wait_ms,
                               m_tdata[70:40]);
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last: expected %0b actual %0b", e.last, m_tlast);
                        errors++;
                    end
                end
            end
            // register write; index 3 is ignored
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WAIT_FLOOR:   floor_r = cfg_data;
                    CFG_WAIT_CEILING: ceiling_r = cfg_data;
                    CFG_LATE_LIMIT:   late_r = cfg_data;
                    default: ;
                endcase
            end
            // input transaction
            if (s_tvalid && s_tready)
                schedule_step(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[63:40],
                              s_tdata[64], s_tdata[96:65]);
        end
    end
endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the timer task scheduler testbench: clock, reset, stimulus and verdict.
// Depends on tts_pkg, timer_task_scheduler and tts_checker.
`timescale 1ns / 100ps
module tb_top;
    import tts_pkg::*;

    localparam int          SLOTS      = 16;
    localparam int          FIRE_CAP   = 63;
    localparam logic [1:0]  CFG_UNUSED = 2'd3;
    localparam logic        MODE_ADD   = 1'b0;
    localparam logic        MODE_POLL  = 1'b1;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;
    int           errors;
    int           pending;

    logic [31:0]  clock_ms;
    int           periodic_left;

    timer_task_scheduler #(.NUM_SLOTS(SLOTS), .MAX_FIRES(FIRE_CAP)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    tts_checker #(.NUM_SLOTS(SLOTS), .MAX_FIRES(FIRE_CAP)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .errors(errors), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver stalls: mostly short, a few long, with quiet stretches
    initial begin
        int stall;
        int quiet;
        int r;
        stall = 0;
        quiet = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                r = $urandom_range(0, 999);
                if (quiet > 0)
                    quiet--;
                else if (r < 5)
                    quiet = $urandom_range(50, 300);
                else if (r < 25)
                    stall = $urandom_range(15, 40);
                else if (r < 200)
                    stall = $urandom_range(1, 3);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // one input transaction
    task automatic send_item(logic mode, logic [7:0] id, logic [31:0] due,
                             logic [23:0] ivl, logic per, logic [31:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser = mode;
        s_tdata = {7'd0, now, per, ivl, due, id};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg_index = idx;
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // hold off until every expected result has come, then let the block settle
    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (SLOTS + 8) @(negedge aclk);
    endtask

    task automatic set_regs(logic [15:0] fl, logic [15:0] ce, logic [15:0] lt);
        drain();
        write_reg(CFG_WAIT_FLOOR, fl);
        write_reg(CFG_WAIT_CEILING, ce);
        write_reg(CFG_LATE_LIMIT, lt);
    endtask

    // random traffic: mostly adds near the running time and polls that advance it
    task automatic random_phase(int count);
        int          r;
        logic [31:0] due;
        logic [23:0] ivl;
        logic        per;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                per = $urandom_range(0, 1);
                if (per && periodic_left == 0) per = 1'b0;
                if (per) periodic_left--;
                send_item(1'($urandom_range(0, 1)), 8'($urandom), $urandom,
                          24'($urandom), per, $urandom);
            end else if (r < 55) begin
                if ($urandom_range(0, 3) == 0)
                    due = clock_ms - $urandom_range(0, 3000);
                else
                    due = clock_ms + $urandom_range(0, 4000);
                ivl = ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                                  : 24'($urandom_range(1, 2000));
                per = (periodic_left > 0 && $urandom_range(0, 7) == 0);
                if (per) periodic_left--;
                send_item(MODE_ADD, 8'($urandom), due, ivl, per, '0);
            end else begin
                if ($urandom_range(0, 19) == 0)
                    clock_ms += $urandom_range(20000, 200000);
                else
                    clock_ms += $urandom_range(0, 1500);
                send_item(MODE_POLL, '0, '0, '0, 1'b0, clock_ms);
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        periodic_left = 6;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty queue at poll start
        send_item(MODE_POLL, '0, '0, '0, 1'b0, 32'd0);
        // fill every slot with one-shots, some sharing a due time, then overflow
        send_item(MODE_ADD, 8'd0, 32'd0, 24'd0, 1'b0, '0);
        send_item(MODE_ADD, 8'hFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        for (int i = 2; i < SLOTS; i++)
            send_item(MODE_ADD, 8'(i), 32'd500 + 32'(i % 3), 24'd10, 1'b0, '0);
        send_item(MODE_ADD, 8'hAA, 32'd1, 24'd1, 1'b0, '0);
        // everything late, fires all and empties the queue
        send_item(MODE_POLL, '0, '0, '0, 1'b0, 32'd100000);
        // on time firing keeps the due time; an early poll reports the distance
        send_item(MODE_ADD, 8'h11, 32'd105000, 24'd0, 1'b0, '0);
        send_item(MODE_ADD, 8'h12, 32'd106000, 24'd0, 1'b0, '0);
        send_item(MODE_POLL, '0, '0, '0, 1'b0, 32'd105500);
        send_item(MODE_POLL, '0, '0, '0, 1'b0, 32'd105900);
        send_item(MODE_POLL, '0, '0, '0, 1'b0, 32'd106000);
        // periodic task rescheduled by its interval
        send_item(MODE_ADD, 8'h77, 32'd107000, 24'd300, 1'b1, '0);
        periodic_left--;
        send_item(MODE_POLL, '0, '0, '0, 1'b0, 32'd107000);
        send_item(MODE_POLL, '0, '0, '0, 1'b0, 32'd107350);

        // random phases, each with its own register setting
        clock_ms = 32'hFFFE_8000;
        set_regs(16'd0, 16'hFFFF, 16'd0);
        write_reg(CFG_UNUSED, 16'h5A5A);
        random_phase(110);
        set_regs(16'hFFFF, 16'd0, 16'hFFFF);
        random_phase(110);
        // sender pauses until the queue of results runs dry
        drain();
        random_phase(10);
        set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(0, 3000)));
        random_phase(110);
        set_regs(16'd50, 16'd1000, 16'd1000);
        random_phase(110);

        // zero-interval periodic task: refires until the fire cap
        drain();
        send_item(MODE_ADD, 8'h5C, clock_ms - 32'd10, 24'd0, 1'b1, '0);
        send_item(MODE_POLL, '0, '0, '0, 1'b0, clock_ms);

        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
